// ----- design/met_pkg.sv -----
package met_pkg;

  localparam int COORD_BITS = 64;
  localparam int FRAC_BITS  = 60;
  localparam int INDEX_BITS = 22;
  localparam int ITER_BITS  = 16;

  // magnitudes and squared terms are kept at full 64 bits
  localparam int MAG_W  = 64;
  localparam int HALF_W = MAG_W / 2;
  localparam int PROD_W = 2 * MAG_W;
  // signed sums of a squared term and a coordinate
  localparam int WIDE_W = MAG_W + 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ESC_RAD_SQ = CFG_IDX_W'(1);

  localparam logic [ITER_BITS-1:0]  MAX_ITER_RST = ITER_BITS'(1000);
  localparam logic [COORD_BITS-2:0] ESC_RAD_RST  = (COORD_BITS-1)'(4) << FRAC_BITS;

  localparam int IN_W       = 2 * COORD_BITS + INDEX_BITS;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = INDEX_BITS + ITER_BITS;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic start;
    logic half_shift;  // shift by FRAC_BITS-1 instead of FRAC_BITS (doubles the product)
  } mul_req_t;

  localparam logic signed [WIDE_W-1:0] COORD_MAX =
    {{(WIDE_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] COORD_MIN = ~COORD_MAX;

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] c;
    c = v;
    if (v > COORD_MAX) begin
      c = COORD_MAX;
    end else if (v < COORD_MIN) begin
      c = COORD_MIN;
    end
    return $signed(c[COORD_BITS-1:0]);
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [COORD_BITS-1:0] v);
    logic [MAG_W-1:0] e;
    e = MAG_W'(v);
    return v[COORD_BITS-1] ? (~e + MAG_W'(1)) : e;
  endfunction

endpackage

// ----- design/met_mul.sv -----
module met_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  met_pkg::mul_req_t          req_i,
  input  logic [met_pkg::MAG_W-1:0]  a_i,
  input  logic [met_pkg::MAG_W-1:0]  b_i,
  output logic                       done_o,
  output logic [met_pkg::MAG_W-1:0]  res_o
);

  localparam int HW = met_pkg::HALF_W;
  localparam int MW = met_pkg::MAG_W;
  localparam int PW = met_pkg::PROD_W;
  localparam logic [2:0] LAST_STEP = 3'd4;

  logic          busy_r;
  logic          done_r;
  logic [2:0]    step_r;
  logic          half_r;
  logic [MW-1:0] a_r;
  logic [MW-1:0] b_r;
  logic [MW-1:0] pp_r;
  logic [PW-1:0] acc_r;

  logic [HW-1:0] a_part;
  logic [HW-1:0] b_part;
  logic [MW-1:0] pp_nxt;
  logic [PW-1:0] addend;
  logic [PW-1:0] shifted;

  // steps 0..3 take a0*b0, a0*b1, a1*b0, a1*b1; accumulate lags one step
  always_comb begin
    a_part = step_r[1] ? a_r[MW-1:HW] : a_r[HW-1:0];
    b_part = step_r[0] ? b_r[MW-1:HW] : b_r[HW-1:0];
    pp_nxt = a_part * b_part;
    case (step_r)
      3'd1:         addend = PW'(pp_r);
      3'd2, 3'd3:   addend = PW'(pp_r) << HW;
      3'd4:         addend = PW'(pp_r) << MW;
      default:      addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      a_r    <= a_i;
      b_r    <= b_i;
      half_r <= req_i.half_shift;
      acc_r  <= '0;
    end else if (busy_r) begin
      pp_r  <= pp_nxt;
      acc_r <= acc_r + addend;
    end
  end

  // saturate when anything is left above the 64-bit window
  always_comb begin
    shifted = half_r ? (acc_r >> (met_pkg::FRAC_BITS - 1)) : (acc_r >> met_pkg::FRAC_BITS);
    res_o   = (|shifted[PW-1:MW]) ? {MW{1'b1}} : shifted[MW-1:0];
    done_o  = done_r;
  end

endmodule

// ----- design/mandelbrot_escape_time_core.sv -----
// Each iteration takes three 64x64 products, each four passes through one
// shared 32x32 multiplier, then the escape test and the update.
// Throughput: one item at a time; the next item is accepted once the result is loaded.
// Reset (rst_n, synchronous): sequencer idle, output empty, iteration limit 1000,
// squared escape radius 4.0.
module mandelbrot_escape_time_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // c_real, c_imag, pixel_index, zero pad
  input  logic [met_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pixel_out_index, iteration_count, zero pad
  output logic [met_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [met_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [met_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CB = met_pkg::COORD_BITS;
  localparam int IB = met_pkg::INDEX_BITS;
  localparam int NB = met_pkg::ITER_BITS;
  localparam int MW = met_pkg::MAG_W;
  localparam int WW = met_pkg::WIDE_W;

  localparam logic [1:0] SEL_XX = 2'd0;
  localparam logic [1:0] SEL_YY = 2'd1;
  localparam logic [1:0] SEL_XY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_WAIT, S_ESC, S_UPDX, S_UPDY, S_MAG, S_OUT
  } state_t;

  state_t                 state_r;
  met_pkg::mul_req_t      req_r;
  logic [1:0]             sel_r;
  logic [NB-1:0]          max_iter_r;
  logic [CB-2:0]          esc_rad_r;

  logic signed [CB-1:0]   cr_r;
  logic signed [CB-1:0]   ci_r;
  logic [IB-1:0]          idx_r;
  logic [NB-1:0]          count_r;
  logic [NB-1:0]          res_cnt_r;
  logic signed [CB-1:0]   x_r;
  logic signed [CB-1:0]   y_r;
  logic [MW-1:0]          xm_r;
  logic [MW-1:0]          ym_r;
  logic                   xneg_r;
  logic                   yneg_r;
  logic [MW-1:0]          xx_r;
  logic [MW-1:0]          yy_r;
  logic [MW-1:0]          p_r;
  logic signed [WW-1:0]   diff_r;
  logic signed [WW-1:0]   ps_r;

  logic                   out_valid_r;
  logic [IB-1:0]          out_idx_r;
  logic [NB-1:0]          out_cnt_r;

  logic [MW-1:0]          mul_a;
  logic [MW-1:0]          mul_b;
  logic                   mul_done;
  logic [MW-1:0]          mul_res;

  logic [MW:0]            mag_sum;
  logic                   escaped;
  logic                   p_neg;
  logic signed [WW-1:0]   diff_nxt;
  logic signed [WW-1:0]   ps_nxt;
  logic signed [WW-1:0]   x_sum;
  logic signed [WW-1:0]   y_sum;

  always_comb begin
    mul_a    = (sel_r == SEL_YY) ? ym_r : xm_r;
    mul_b    = (sel_r == SEL_XX) ? xm_r : ym_r;
    mag_sum  = {1'b0, xx_r} + {1'b0, yy_r};
    escaped  = mag_sum >= (MW+1)'(esc_rad_r);
    p_neg    = (|p_r) && (xneg_r != yneg_r);
    diff_nxt = $signed(WW'(xx_r)) - $signed(WW'(yy_r));
    ps_nxt   = p_neg ? ($signed(WW'(0)) - $signed(WW'(p_r))) : $signed(WW'(p_r));
    x_sum    = diff_r + WW'(cr_r);
    y_sum    = ps_r + WW'(ci_r);
  end

  met_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (req_r),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = met_pkg::OUT_TDATA_W'({out_cnt_r, out_idx_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_r       <= '0;
      out_valid_r <= 1'b0;
      max_iter_r  <= met_pkg::MAX_ITER_RST;
      esc_rad_r   <= met_pkg::ESC_RAD_RST;
    end else begin
      req_r.start <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_index)
          met_pkg::REG_MAX_ITER:   max_iter_r <= cfg_data[NB-1:0];
          met_pkg::REG_ESC_RAD_SQ: esc_rad_r  <= cfg_data[CB-2:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cr_r    <= $signed(in_tdata[CB-1:0]);
            ci_r    <= $signed(in_tdata[2*CB-1:CB]);
            idx_r   <= in_tdata[2*CB+IB-1:2*CB];
            count_r <= '0;
            xm_r    <= '0;
            ym_r    <= '0;
            xneg_r  <= 1'b0;
            yneg_r  <= 1'b0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (count_r < max_iter_r) begin
            sel_r            <= SEL_XX;
            req_r.start      <= 1'b1;
            req_r.half_shift <= 1'b0;
            state_r          <= S_WAIT;
          end else begin
            // limit reached: report zero
            res_cnt_r <= '0;
            state_r   <= S_OUT;
          end
        end
        S_WAIT: begin
          if (mul_done) begin
            unique case (sel_r)
              SEL_XX: begin
                xx_r             <= mul_res;
                sel_r            <= SEL_YY;
                req_r.start      <= 1'b1;
                req_r.half_shift <= 1'b0;
              end
              SEL_YY: begin
                yy_r             <= mul_res;
                sel_r            <= SEL_XY;
                req_r.start      <= 1'b1;
                req_r.half_shift <= 1'b1;
              end
              default: begin
                p_r     <= mul_res;
                state_r <= S_ESC;
              end
            endcase
          end
        end
        S_ESC: begin
          if (escaped) begin
            res_cnt_r <= count_r;
            state_r   <= S_OUT;
          end else begin
            diff_r  <= diff_nxt;
            ps_r    <= ps_nxt;
            state_r <= S_UPDX;
          end
        end
        S_UPDX: begin
          x_r     <= met_pkg::clamp_coord(x_sum);
          state_r <= S_UPDY;
        end
        S_UPDY: begin
          y_r     <= met_pkg::clamp_coord(y_sum);
          count_r <= count_r + NB'(1);
          state_r <= S_MAG;
        end
        S_MAG: begin
          xm_r    <= met_pkg::mag_of(x_r);
          ym_r    <= met_pkg::mag_of(y_r);
          xneg_r  <= x_r[CB-1];
          yneg_r  <= y_r[CB-1];
          state_r <= S_CHECK;
        end
        S_OUT: begin
          // load only when the output register is free or being taken
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= idx_r;
            out_cnt_r   <= res_cnt_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/mandelbrot_escape_time_core_test.sv -----
module mandelbrot_escape_time_core_test;

  localparam int COORD_BITS  = met_pkg::COORD_BITS;
  localparam int FRAC_BITS   = met_pkg::FRAC_BITS;
  localparam int INDEX_BITS  = met_pkg::INDEX_BITS;
  localparam int ITER_BITS   = met_pkg::ITER_BITS;
  localparam int MAG_W       = met_pkg::MAG_W;
  localparam int PROD_W      = met_pkg::PROD_W;
  localparam int CFG_IDX_W   = met_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = met_pkg::CFG_DATA_W;
  localparam int IN_W        = met_pkg::IN_W;
  localparam int IN_TDATA_W  = met_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = met_pkg::OUT_TDATA_W;

  // writes to these indexes must leave both registers untouched
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam int WATCHDOG_CYCLES = 200000;
  localparam int NUM_PHASES      = 8;
  localparam int PHASE_ITEMS     = 25;
  localparam int LONG_HOLD       = 3000;
  localparam int HOLD_AT         = 50;
  localparam int SETTLE          = 40;
  localparam int WIDE_BITS       = COORD_BITS + 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;

  // Q4.60 points of interest
  localparam coord_t Q_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam coord_t Q_MIN   = 64'h8000_0000_0000_0000;
  localparam coord_t Q_ONE   = 64'h1000_0000_0000_0000;
  localparam coord_t Q_M_ONE = 64'hF000_0000_0000_0000;
  localparam coord_t Q_TWO   = 64'h2000_0000_0000_0000;
  localparam coord_t Q_M_TWO = 64'hE000_0000_0000_0000;
  localparam coord_t Q_2P5   = 64'h2800_0000_0000_0000;
  localparam coord_t Q_HALF  = 64'h0800_0000_0000_0000;
  localparam coord_t Q_M_HALF = 64'hF800_0000_0000_0000;
  localparam coord_t Q_QUART = 64'h0400_0000_0000_0000;
  localparam coord_t Q_0P26  = 64'h0428_F5C2_8F5C_28F6;
  localparam coord_t Q_M_0P75 = 64'hF400_0000_0000_0000;
  localparam coord_t Q_0P1   = 64'h0199_9999_9999_999A;

  localparam wide_t W_HI = wide_t'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam wide_t W_LO = ~W_HI;

  typedef struct packed {
    logic [INDEX_BITS-1:0] pix;
    logic [ITER_BITS-1:0]  count;
  } escape_result_t;

  typedef enum logic {ROW_POINT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    coord_t                c_re;
    coord_t                c_im;
    logic [INDEX_BITS-1:0] pix;
    logic                  typed;
    logic [ITER_BITS-1:0]  count;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic [ITER_BITS-1:0]   cur_max_iter = met_pkg::MAX_ITER_RST;
  logic [COORD_BITS-2:0]  cur_radius = met_pkg::ESC_RAD_RST;

  escape_result_t pending_escapes[$];
  plan_row_t      plan[$];
  int             fails = 0;
  int             results_seen = 0;
  int             quiet = 0;

  mandelbrot_escape_time_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [MAG_W-1:0] prod_shift(logic [MAG_W-1:0] a, logic [MAG_W-1:0] b,
                                                  int unsigned s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b);
    p = p >> s;
    return (p[PROD_W-1:MAG_W] != '0) ? '1 : p[MAG_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] magnitude(coord_t v);
    return v[COORD_BITS-1] ? (~MAG_W'(v) + 1'b1) : MAG_W'(v);
  endfunction

  function automatic coord_t saturate(wide_t v);
    if (v > W_HI) return W_HI[COORD_BITS-1:0];
    if (v < W_LO) return W_LO[COORD_BITS-1:0];
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic [ITER_BITS-1:0] escape_count(coord_t cr, coord_t ci,
                                                        logic [ITER_BITS-1:0] lim,
                                                        logic [COORD_BITS-2:0] rad);
    coord_t           x;
    coord_t           y;
    logic [MAG_W-1:0] xm, ym, xx, yy, pm, mag2;
    logic [MAG_W:0]   s;
    wide_t            re, im, pw;
    int unsigned      n;
    bit               gone;
    x = '0;
    y = '0;
    n = 0;
    gone = 1'b0;
    while (n < lim && !gone) begin
      xm = magnitude(x);
      ym = magnitude(y);
      xx = prod_shift(xm, xm, FRAC_BITS);
      yy = prod_shift(ym, ym, FRAC_BITS);
      s = {1'b0, xx} + {1'b0, yy};
      mag2 = s[MAG_W] ? '1 : s[MAG_W-1:0];
      if (mag2 >= MAG_W'(rad)) begin
        gone = 1'b1;
      end else begin
        pm = prod_shift(xm, ym, FRAC_BITS - 1);
        pw = $signed({4'b0000, pm});
        if (x[COORD_BITS-1] != y[COORD_BITS-1]) pw = -pw;
        re = $signed({4'b0000, xx}) - $signed({4'b0000, yy}) + wide_t'(cr);
        im = pw + wide_t'(ci);
        x = saturate(re);
        y = saturate(im);
        n++;
      end
    end
    return (n == lim) ? '0 : ITER_BITS'(n);
  endfunction

  function automatic plan_row_t point_row(coord_t cr, coord_t ci, logic [INDEX_BITS-1:0] pix,
                                          logic typed, logic [ITER_BITS-1:0] count);
    plan_row_t r;
    r = '0;
    r.kind = ROW_POINT;
    r.c_re = cr;
    r.c_im = ci;
    r.pix = pix;
    r.typed = typed;
    r.count = count;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  task automatic build_plan;
    // defaults after reset: limit 1000, radius 4.0
    plan.push_back(point_row('0, '0, 22'h000000, 1'b1, 16'd0));
    plan.push_back(point_row(Q_MAX, Q_MAX, 22'h3FFFFF, 1'b1, 16'd1));
    plan.push_back(point_row(Q_MIN, Q_MIN, 22'h155555, 1'b1, 16'd1));
    plan.push_back(point_row(Q_MIN, Q_MAX, 22'h2AAAAA, 1'b1, 16'd1));
    plan.push_back(point_row(Q_M_TWO, '0, 22'd1, 1'b0, '0));
    plan.push_back(point_row(Q_QUART, '0, 22'd2, 1'b0, '0));
    plan.push_back(point_row(Q_M_0P75, Q_0P1, 22'd3, 1'b0, '0));
    plan.push_back(point_row(Q_ONE, Q_ONE, 22'd4, 1'b0, '0));
    plan.push_back(point_row(64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 22'd5, 1'b0, '0));
    plan.push_back(reg_row(met_pkg::REG_MAX_ITER, 64'd65535));
    plan.push_back(point_row(Q_MAX, Q_MIN, 22'd6, 1'b1, 16'd1));
    plan.push_back(point_row(Q_0P26, '0, 22'd7, 1'b0, '0));
    plan.push_back(reg_row(met_pkg::REG_ESC_RAD_SQ, 64'h7FFF_FFFF_FFFF_FFFF));
    plan.push_back(point_row(Q_HALF, Q_HALF, 22'd8, 1'b0, '0));
    plan.push_back(point_row(Q_MAX, Q_MAX, 22'd9, 1'b1, 16'd1));
    // limit of one: every point that survives the first step hits the limit
    plan.push_back(reg_row(met_pkg::REG_MAX_ITER, 64'd1));
    plan.push_back(point_row('0, '0, 22'd10, 1'b1, 16'd0));
    plan.push_back(point_row(Q_MIN, '0, 22'd11, 1'b1, 16'd0));
    plan.push_back(reg_row(met_pkg::REG_ESC_RAD_SQ, 64'd0));
    plan.push_back(point_row(Q_QUART, Q_M_HALF, 22'd12, 1'b1, 16'd0));
    plan.push_back(reg_row(met_pkg::REG_MAX_ITER, 64'd0));
    plan.push_back(point_row(Q_ONE, Q_ONE, 22'd13, 1'b1, 16'd0));
    // bits above the register width are dropped: limit 7, radius 4.0
    plan.push_back(reg_row(met_pkg::REG_MAX_ITER, 64'hFFFF_FFFF_FFFF_0007));
    plan.push_back(reg_row(met_pkg::REG_ESC_RAD_SQ, 64'hC000_0000_0000_0000));
    plan.push_back(point_row('0, '0, 22'd14, 1'b1, 16'd0));
    plan.push_back(point_row(Q_ONE, '0, 22'd15, 1'b0, '0));
    plan.push_back(reg_row(REG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(reg_row(REG_SPARE_B, 64'h0000_0000_0000_0000));
    plan.push_back(point_row(Q_M_ONE, '0, 22'd16, 1'b1, 16'd0));
    plan.push_back(point_row(Q_HALF, Q_M_HALF, 22'd17, 1'b0, '0));
  endtask

  function automatic coord_t edge_coord();
    case ($urandom_range(0, 6))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return 64'hFFFF_FFFF_FFFF_FFFF;
      4: return 64'd1;
      5: return Q_ONE;
      default: return Q_M_TWO;
    endcase
  endfunction

  task automatic idle_gap(bit calm);
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (!calm && r >= 70) begin
      g = (r < 93) ? $urandom_range(1, 4) : $urandom_range(15, 60);
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // valid stays high after acceptance; the next offer or a drain decides
  task automatic offer_point(coord_t cr, coord_t ci, logic [INDEX_BITS-1:0] pix, logic typed,
                             logic [ITER_BITS-1:0] typed_count, bit calm);
    escape_result_t want;
    idle_gap(calm);
    want.pix = pix;
    want.count = typed ? typed_count : escape_count(cr, ci, cur_max_iter, cur_radius);
    in_tdata <= {{(IN_TDATA_W-IN_W){1'b0}}, pix, ci, cr};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_escapes.push_back(want);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_escapes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == met_pkg::REG_MAX_ITER) begin
      cur_max_iter = value[ITER_BITS-1:0];
    end else if (idx == met_pkg::REG_ESC_RAD_SQ) begin
      cur_radius = value[COORD_BITS-2:0];
    end
  endtask

  initial begin : stimulus
    coord_t                cr;
    coord_t                ci;
    logic [CFG_DATA_W-1:0] v;
    logic [ITER_BITS-1:0]  lim;
    int                    k;
    bit                    calm;
    build_plan();
    do @(posedge clk); while (!rst_n);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        offer_point(plan[i].c_re, plan[i].c_im, plan[i].pix, plan[i].typed, plan[i].count,
                    1'b0);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      // most limits small to keep the run short; one phase goes deeper
      lim = (p == 3) ? 16'd256 : ITER_BITS'($urandom_range(1, 48));
      v = {$urandom(), 16'($urandom()), lim};
      write_reg(met_pkg::REG_MAX_ITER, v);
      @(posedge clk);
      case ($urandom_range(0, 5))
        0: v = {1'($urandom()), met_pkg::ESC_RAD_RST};
        1: v = {$urandom(), $urandom()};
        2: v = {1'b0, 3'($urandom()), 28'($urandom()), $urandom()};
        3: v = 64'h7FFF_FFFF_FFFF_FFFF;
        default: v = {1'b0, met_pkg::ESC_RAD_RST};
      endcase
      write_reg(met_pkg::REG_ESC_RAD_SQ, v);
      calm = (p % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        k = $urandom_range(0, 9);
        if (k <= 6) begin
          // around the set: real in [-2.5, 1.5), imaginary in [-2, 2)
          cr = coord_t'({$urandom(), $urandom()} & 64'h3FFF_FFFF_FFFF_FFFF) - Q_2P5;
          ci = coord_t'({$urandom(), $urandom()} & 64'h3FFF_FFFF_FFFF_FFFF) - Q_TWO;
        end else if (k <= 8) begin
          cr = {$urandom(), $urandom()};
          ci = {$urandom(), $urandom()};
        end else begin
          cr = edge_coord();
          ci = edge_coord();
        end
        offer_point(cr, ci, INDEX_BITS'($urandom()), 1'b0, '0, calm);
      end
    end

    drain();
    if (fails == 0 && pending_escapes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : result_side
    int gap;
    int r;
    bit calm;
    bit held;
    gap = 0;
    calm = 1'b0;
    held = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        // long back-pressure so the block holds a result and stalls its input
        held = 1'b1;
        gap = LONG_HOLD;
      end else if (gap == 0 && $urandom_range(0, 299) == 0) begin
        calm = !calm;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        gap--;
      end else begin
        r = $urandom_range(0, 99);
        if (calm || r < 70) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          gap = (r < 94) ? $urandom_range(0, 3) : $urandom_range(15, 80);
        end
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_result
    escape_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (pending_escapes.size() == 0) begin
        $error("result with no item pending: pixel_out_index %0d iteration_count %0d",
               out_tdata[INDEX_BITS-1:0], out_tdata[INDEX_BITS +: ITER_BITS]);
        fails++;
      end else begin
        want = pending_escapes.pop_front();
        if (out_tdata[INDEX_BITS-1:0] !== want.pix) begin
          $error("pixel_out_index: expected %0d, got %0d", want.pix,
                 out_tdata[INDEX_BITS-1:0]);
          fails++;
        end
        if (out_tdata[INDEX_BITS +: ITER_BITS] !== want.count) begin
          $error("iteration_count: expected %0d, got %0d", want.count,
                 out_tdata[INDEX_BITS +: ITER_BITS]);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
